// ===== rtl/tidu_pkg.sv =====
// ---------------------------------------------------------------------------
// Thumb instruction decoder package
// Shared types and code points for the Thumb instruction decoder.
// ---------------------------------------------------------------------------
package tidu_pkg;

    typedef logic [1:0] status_t;
    typedef logic [3:0] iclass_t;
    typedef logic [5:0] opcode_t;
    typedef logic [3:0] cond_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_UNASSIGN  = 2'd1;
    localparam status_t ST_NODECODE  = 2'd2;
    localparam status_t ST_UNDEF     = 2'd3;

    localparam iclass_t CL_BRANCH = 4'd0;
    localparam iclass_t CL_DP1    = 4'd1;
    localparam iclass_t CL_DP2    = 4'd2;
    localparam iclass_t CL_DP3    = 4'd3;
    localparam iclass_t CL_DP4    = 4'd4;
    localparam iclass_t CL_DP5    = 4'd5;
    localparam iclass_t CL_DP6    = 4'd6;
    localparam iclass_t CL_DP7    = 4'd7;
    localparam iclass_t CL_DP8    = 4'd8;
    localparam iclass_t CL_LS     = 4'd9;
    localparam iclass_t CL_LSM    = 4'd10;
    localparam iclass_t CL_EXC    = 4'd11;

    localparam opcode_t OPC_B_COND      = 6'd0;
    localparam opcode_t OPC_B_IMM       = 6'd1;
    localparam opcode_t OPC_BL_HIGH     = 6'd2;
    localparam opcode_t OPC_BL          = 6'd3;
    localparam opcode_t OPC_BX          = 6'd4;
    localparam opcode_t OPC_ADD_REG     = 6'd5;
    localparam opcode_t OPC_LSL_IMM     = 6'd9;
    localparam opcode_t OPC_MOV_IMM     = 6'd12;
    localparam opcode_t OPC_AND         = 6'd16;
    localparam opcode_t OPC_ADD_IMM_PC  = 6'd32;
    localparam opcode_t OPC_ADD_INC_SP  = 6'd34;
    localparam opcode_t OPC_ADD_HIG_REG = 6'd36;
    localparam opcode_t OPC_STR_IMM     = 6'd39;
    localparam opcode_t OPC_STR_REG     = 6'd45;
    localparam opcode_t OPC_LDR_PC      = 6'd53;
    localparam opcode_t OPC_LDR_SP      = 6'd54;
    localparam opcode_t OPC_STR_SP      = 6'd55;
    localparam opcode_t OPC_LDMIA       = 6'd56;
    localparam opcode_t OPC_STMIA       = 6'd57;
    localparam opcode_t OPC_POP         = 6'd58;
    localparam opcode_t OPC_PUSH        = 6'd59;
    localparam opcode_t OPC_SWI         = 6'd60;
    localparam opcode_t OPC_NONE        = 6'd61;

    localparam cond_t COND_AL = 4'b1110;

    localparam logic [2:0] TOP3_SHIFT  = 3'b000;
    localparam logic [2:0] TOP3_IMM    = 3'b001;
    localparam logic [2:0] TOP3_BRANCH = 3'b111;
    localparam logic [5:0] PFX_ALU     = 6'b010000;
    localparam logic [5:0] PFX_HIREG   = 6'b010001;
    localparam logic [7:0] PFX_BX      = 8'b01000111;
    localparam logic [4:0] PFX_LDR_PC  = 5'b01001;
    localparam logic [4:0] PFX_LS_IMM  = 5'd12;
    localparam logic [3:0] SUB_UNDEF   = 4'b1110;
    localparam logic [3:0] SUB_SWI     = 4'b1111;
    localparam logic [3:0] SUB_SP_ADJ  = 4'b0000;

    typedef struct packed {
        status_t      status;
        iclass_t      instr_class;
        opcode_t      opcode;
        cond_t        condition;
        logic [10:0]  operand_a;
        logic [3:0]   operand_b;
        logic [4:0]   operand_c;
    } decode_t;

endpackage

// ===== rtl/thumb_instruction_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// Thumb instruction decoder unit
// Each accepted instruction beat is registered in the input stage, then in the result stage.
// Throughput: one beat per cycle while out_stall is low, set by the single-pass decode
// between the input register and the result register.
// Reset clears both stage valid flags; no other state is reset.
// ---------------------------------------------------------------------------
module thumb_instruction_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] instruction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  instr_class,
    output logic [5:0]  opcode,
    output logic [3:0]  condition,
    output logic [10:0] operand_a,
    output logic [3:0]  operand_b,
    output logic [4:0]  operand_c
);
    import tidu_pkg::*;

    logic        res_load;
    logic        word_valid;
    logic [15:0] word;
    decode_t     dec;
    decode_t     res;

    tidu_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .instruction (instruction),
        .res_load    (res_load),
        .word_valid  (word_valid),
        .word        (word)
    );

    tidu_decode u_decode (
        .word (word),
        .dec  (dec)
    );

    tidu_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (word_valid),
        .dec       (dec),
        .res_load  (res_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign status      = res.status;
    assign instr_class = res.instr_class;
    assign opcode      = res.opcode;
    assign condition   = res.condition;
    assign operand_a   = res.operand_a;
    assign operand_b   = res.operand_b;
    assign operand_c   = res.operand_c;
endmodule

// ===== rtl/tidu_in_stage.sv =====
// ---------------------------------------------------------------------------
// Thumb decoder input stage
// Registers one instruction beat and holds it while the result stage is full.
// ---------------------------------------------------------------------------
module tidu_in_stage (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] instruction,
    input  logic        res_load,
    output logic        word_valid,
    output logic [15:0] word
);
    logic        valid_reg;
    logic        valid_next;
    logic [15:0] word_reg;
    logic        take;

    assign in_stall   = valid_reg && !res_load;
    assign take       = in_valid && !in_stall;
    assign valid_next = take ? 1'b1 : (res_load ? 1'b0 : valid_reg);
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= instruction;
        end
    end
endmodule

// ===== rtl/tidu_decode.sv =====
// ---------------------------------------------------------------------------
// Thumb decoder format logic
// Matches the format prefixes in priority order and extracts the fields.
// ---------------------------------------------------------------------------
module tidu_decode (
    input  logic            [15:0] word,
    output tidu_pkg::decode_t      dec
);
    import tidu_pkg::*;

    logic [2:0]  r0;
    logic [2:0]  r3;
    logic [2:0]  r8;
    logic [7:0]  imm8;
    logic [3:0]  sub4;
    logic        b11;
    logic [1:0]  h;

    assign r0   = word[2:0];
    assign r3   = word[5:3];
    assign r8   = word[10:8];
    assign imm8 = word[7:0];
    assign sub4 = word[11:8];
    assign b11  = word[11];
    assign h    = word[12:11];

    always_comb
    begin
        dec.status      = ST_OK;
        dec.instr_class = CL_BRANCH;
        dec.opcode      = OPC_NONE;
        dec.condition   = COND_AL;
        dec.operand_a   = '0;
        dec.operand_b   = '0;
        dec.operand_c   = '0;
        priority if (word[15:13] == TOP3_SHIFT)
        begin
            dec.operand_a = {8'd0, r0};
            dec.operand_b = {1'b0, r3};
            if (h == 2'b11)
            begin
                dec.instr_class = word[10] ? CL_DP2 : CL_DP1;
                dec.opcode      = OPC_ADD_REG + {4'd0, word[10:9]};
                dec.operand_c   = {2'd0, word[8:6]};
            end
            else
            begin
                dec.instr_class = CL_DP4;
                dec.opcode      = OPC_LSL_IMM + {4'd0, h};
                dec.operand_c   = word[10:6];
            end
        end
        else if (word[15:13] == TOP3_IMM)
        begin
            dec.instr_class = CL_DP3;
            dec.opcode      = OPC_MOV_IMM + {4'd0, h};
            dec.operand_a   = {3'd0, imm8};
            dec.operand_b   = {1'b0, r8};
        end
        else if (word[15:13] == TOP3_BRANCH)
        begin
            dec.operand_a = word[10:0];
            dec.operand_b = {2'd0, h};
            unique case (h)
                2'b00:   dec.opcode = OPC_B_IMM;
                2'b01:   dec.status = ST_UNASSIGN;
                2'b10:   dec.opcode = OPC_BL_HIGH;
                default: dec.opcode = OPC_BL;
            endcase
        end
        else if (word[15:10] == PFX_ALU)
        begin
            dec.instr_class = CL_DP5;
            dec.opcode      = OPC_AND + {2'd0, word[9:6]};
            dec.operand_a   = {8'd0, r0};
            dec.operand_b   = {1'b0, r3};
        end
        else if (word[15:8] == PFX_BX)
        begin
            dec.operand_a = {7'd0, word[6:3]};
            if (word[7])
            begin
                dec.status = ST_UNASSIGN;
            end
            else
            begin
                dec.opcode = OPC_BX;
            end
        end
        else if (word[15:10] == PFX_HIREG)
        begin
            dec.instr_class = CL_DP8;
            dec.opcode      = OPC_ADD_HIG_REG + {4'd0, word[9:8]};
            dec.operand_a   = {7'd0, word[7], r0};
            dec.operand_b   = word[6:3];
        end
        else if (word[15:11] == PFX_LDR_PC)
        begin
            dec.instr_class = CL_LS;
            dec.opcode      = OPC_LDR_PC;
            dec.operand_a   = {3'd0, imm8};
            dec.operand_b   = {1'b0, r8};
        end
        else
        begin
            unique case (word[15:12])
                4'h5:
                begin
                    dec.instr_class = CL_LS;
                    dec.opcode      = OPC_STR_REG + {3'd0, word[11:9]};
                    dec.operand_a   = {8'd0, r0};
                    dec.operand_b   = {1'b0, r3};
                    dec.operand_c   = {2'd0, word[8:6]};
                end
                4'h6, 4'h7, 4'h8:
                begin
                    dec.instr_class = CL_LS;
                    dec.opcode      = OPC_STR_IMM + {1'b0, word[15:11] - PFX_LS_IMM};
                    dec.operand_a   = {8'd0, r0};
                    dec.operand_b   = {1'b0, r3};
                    dec.operand_c   = word[10:6];
                end
                4'h9:
                begin
                    dec.instr_class = CL_LS;
                    dec.opcode      = b11 ? OPC_LDR_SP : OPC_STR_SP;
                    dec.operand_a   = {3'd0, imm8};
                    dec.operand_b   = {1'b0, r8};
                end
                4'hA:
                begin
                    dec.instr_class = CL_DP6;
                    dec.opcode      = OPC_ADD_IMM_PC + {5'd0, b11};
                    dec.operand_a   = {3'd0, imm8};
                    dec.operand_b   = {1'b0, r8};
                end
                4'hB:
                begin
                    priority if (sub4 == SUB_SP_ADJ)
                    begin
                        dec.instr_class = CL_DP7;
                        dec.opcode      = OPC_ADD_INC_SP + {5'd0, word[7]};
                        dec.operand_a   = {4'd0, word[6:0]};
                    end
                    else if (sub4 == SUB_UNDEF)
                    begin
                        dec.status = ST_NODECODE;
                    end
                    else
                    begin
                        dec.instr_class = CL_LSM;
                        dec.opcode      = b11 ? OPC_POP : OPC_PUSH;
                        dec.operand_a   = {3'd0, imm8};
                        dec.operand_b   = {3'd0, word[8]};
                    end
                end
                4'hC:
                begin
                    dec.instr_class = CL_LSM;
                    dec.opcode      = b11 ? OPC_LDMIA : OPC_STMIA;
                    dec.operand_a   = {3'd0, imm8};
                    dec.operand_b   = {1'b0, r8};
                end
                4'hD:
                begin
                    priority if (sub4 == SUB_UNDEF)
                    begin
                        dec.status = ST_UNDEF;
                    end
                    else if (sub4 == SUB_SWI)
                    begin
                        dec.instr_class = CL_EXC;
                        dec.opcode      = OPC_SWI;
                        dec.operand_a   = {3'd0, imm8};
                    end
                    else
                    begin
                        dec.opcode    = OPC_B_COND;
                        dec.condition = sub4;
                        dec.operand_a = {3'd0, imm8};
                    end
                end
                default:
                begin
                    dec.status = ST_NODECODE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/tidu_out_stage.sv =====
// ---------------------------------------------------------------------------
// Thumb decoder result stage
// Registers the decoded beat and holds it until the consumer takes it.
// ---------------------------------------------------------------------------
module tidu_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              dec_valid,
    input  tidu_pkg::decode_t dec,
    output logic              res_load,
    output logic              out_valid,
    input  logic              out_stall,
    output tidu_pkg::decode_t res
);
    import tidu_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    decode_t res_reg;

    assign res_load   = !valid_reg || !out_stall;
    assign valid_next = res_load ? dec_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign res        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load && dec_valid)
        begin
            res_reg <= dec;
        end
    end
endmodule
